// ===== rtl/mlpbp_pkg.sv =====
// Shared types, constants and helpers for the MLP back-propagation trainer.
// Standalone package; used by mlp_backprop_train_step_top.
package mlpbp_pkg;

   localparam int N_INPUTS_DEF = 11;
   localparam int N_HIDDEN_DEF = 16;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_TRAIN = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_ERROR  = 1'b1;

   localparam logic [16:0] LR_RESET = 17'd655;
   localparam int          Q_ONE    = 65536;
   localparam int          SIG_SIZE = 1024;
   localparam int          SIG_HALF = 512;
   localparam logic signed [31:0] SIG_SPAN = 32'sd524288;
   localparam logic [63:0] EXP_STEP = 64'd4228380000;

   typedef logic [16:0] sig_rom_type [SIG_SIZE];

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Sigmoid table address, clamped at both ends.
   function automatic logic [9:0] sig_index(input logic signed [31:0] x);
      logic signed [31:0] s;
      logic [9:0]         r;
      s = x + SIG_SPAN;
      if (x < -SIG_SPAN) begin
         r = '0;
      end else if (x >= SIG_SPAN) begin
         r = '1;
      end else begin
         r = s[19:10];
      end
      return r;
   endfunction

   // Restoring long division, elaboration use only.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sigmoid table over [-8,8) from the e^(-m/64) recurrence.
   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      logic [95:0] e;
      logic [63:0] d;
      logic [63:0] p;
      e = 96'(1) << 32;
      for (int m = 0; m <= SIG_HALF; m++) begin
         if (m > 0) begin
            e = (e * 96'(EXP_STEP) + (96'(1) << 31)) >> 32;
         end
         d = 64'(e) + (64'(1) << 32);
         p = udiv64((64'(1) << 48) + (d >> 1), d);
         if (m < SIG_HALF) begin
            rom[SIG_HALF + m] = 17'(p);
         end
         if (m >= 1) begin
            rom[SIG_HALF - m] = 17'(64'(Q_ONE) - p);
         end
      end
      return rom;
   endfunction

endpackage

// ===== rtl/mlp_backprop_train_step_top.sv =====
// Online back-propagation trainer for an N_INPUTS-N_HIDDEN-1 sigmoid MLP, Q16.16.
// Depends on mlpbp_pkg (constants, saturation, sigmoid table builder).
// Commands: write weight / load feature are done while busy stays low; read weight passes
//   ST_RD_ISS then ST_RD_OUT, which raises rsp_strobe; train ends with the error in ST_E_OUT.
// Throughput: one command at a time; train time is set by the single shared
//   33x33 multiplier, each use passing through an operand register and a product register.
// Reset (synchronous, active high) clears control and sets the step size to 655;
//   stores are undefined until written. Results cannot be stalled by the receiver.
module mlp_backprop_train_step_top #(
   parameter int N_INPUTS = mlpbp_pkg::N_INPUTS_DEF,
   parameter int N_HIDDEN = mlpbp_pkg::N_HIDDEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_index,
   input  logic signed [31:0] req_value,
   output logic        rsp_strobe,
   output logic        rsp_result_kind,
   output logic signed [31:0] rsp_result_value,
   input  logic        csr_write_en,
   input  logic [16:0] csr_write_data
);
   import mlpbp_pkg::*;

   localparam int NIH = N_INPUTS * N_HIDDEN;
   localparam int NW  = NIH + N_HIDDEN;
   localparam int WAW = $clog2(NW);
   localparam int IW  = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
   localparam int HW  = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;

   localparam sig_rom_type SigRom = build_sig_rom();

   // sequencer codes
   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_RD_ISS = 5'd1;
   localparam logic [4:0] ST_RD_OUT = 5'd2;
   localparam logic [4:0] ST_MUL    = 5'd3;
   localparam logic [4:0] ST_F1_RD  = 5'd4;
   localparam logic [4:0] ST_F1_OP  = 5'd5;
   localparam logic [4:0] ST_F1_ACC = 5'd6;
   localparam logic [4:0] ST_F1_SIG = 5'd7;
   localparam logic [4:0] ST_F1_WR  = 5'd8;
   localparam logic [4:0] ST_F2_RD  = 5'd9;
   localparam logic [4:0] ST_F2_OP  = 5'd10;
   localparam logic [4:0] ST_F2_ACC = 5'd11;
   localparam logic [4:0] ST_F2_SIG = 5'd12;
   localparam logic [4:0] ST_F2_OUT = 5'd13;
   localparam logic [4:0] ST_OD_A   = 5'd14;
   localparam logic [4:0] ST_OD_B   = 5'd15;
   localparam logic [4:0] ST_OD_C   = 5'd16;
   localparam logic [4:0] ST_H_RD   = 5'd17;
   localparam logic [4:0] ST_H_OP   = 5'd18;
   localparam logic [4:0] ST_H_T1   = 5'd19;
   localparam logic [4:0] ST_H_T2   = 5'd20;
   localparam logic [4:0] ST_H_T3   = 5'd21;
   localparam logic [4:0] ST_H_T4   = 5'd22;
   localparam logic [4:0] ST_H_WR   = 5'd23;
   localparam logic [4:0] ST_U_RD   = 5'd24;
   localparam logic [4:0] ST_U_OP   = 5'd25;
   localparam logic [4:0] ST_U_WR   = 5'd26;
   localparam logic [4:0] ST_E_SET  = 5'd27;
   localparam logic [4:0] ST_E_OUT  = 5'd28;

   // storage: weights (input-hidden then hidden-output), features,
   // hidden activations, scaled hidden deltas
   logic signed [31:0] w_mem [NW];
   logic signed [31:0] f_mem [N_INPUTS];
   logic        [16:0] a_mem [N_HIDDEN];
   logic signed [31:0] h_mem [N_HIDDEN];

   logic signed [31:0] w_q_ff, f_q_ff, h_q_ff;
   logic        [16:0] a_q_ff, rom_q_ff;

   logic [WAW-1:0] w_raddr, w_waddr;
   logic [IW-1:0]  f_raddr, f_waddr;
   logic [HW-1:0]  a_raddr, h_raddr, a_waddr, h_waddr;
   logic [9:0]     rom_addr;
   logic           w_we, f_we, a_we, h_we;
   logic signed [31:0] w_wdata, f_wdata, h_wdata;
   logic        [16:0] a_wdata;

   // control and datapath registers
   logic [4:0]     state_ff, state_in, ret_ff, ret_in;
   logic [IW-1:0]  i_ff, i_in;
   logic [HW-1:0]  j_ff, j_in;
   logic [WAW-1:0] k_ff, k_in;
   logic signed [55:0] acc_ff, acc_in;
   logic [7:0]     idx_ff, idx_in;
   logic           hit_ff, hit_in;
   logic signed [31:0] tgt_ff, tgt_in, err_ff, err_in, od_ff, od_in;
   logic signed [31:0] step_ff, step_in, wo_ff, wo_in, t1_ff, t1_in;
   logic        [16:0] act_ff, act_in;
   logic signed [32:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic signed [65:0] prod_ff;
   logic        [16:0] lr_ff, lr_in;

   logic signed [49:0] raw;
   logic signed [31:0] q;
   logic signed [31:0] acc_sat;
   logic               accept;
   logic               i_last, j_last;

   assign raw     = prod_ff[65:16];          // floor(prod / 2^16)
   assign q       = sat32(64'(raw));
   assign acc_sat = sat32(64'(acc_ff));
   assign accept  = start && !busy;
   assign i_last  = (i_ff == IW'(N_INPUTS - 1));
   assign j_last  = (j_ff == HW'(N_HIDDEN - 1));

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = (state_ff == ST_RD_OUT) || (state_ff == ST_E_OUT);
   assign rsp_result_kind  = (state_ff == ST_E_OUT) ? KIND_ERROR : KIND_WEIGHT;
   assign rsp_result_value = (state_ff == ST_E_OUT) ? q : (hit_ff ? w_q_ff : 32'sd0);

   always_comb begin
      state_in = state_ff;  ret_in  = ret_ff;
      i_in     = i_ff;      j_in    = j_ff;     k_in   = k_ff;
      acc_in   = acc_ff;    idx_in  = idx_ff;   hit_in = hit_ff;
      tgt_in   = tgt_ff;    err_in  = err_ff;   od_in  = od_ff;
      step_in  = step_ff;   wo_in   = wo_ff;    t1_in  = t1_ff;
      act_in   = act_ff;    mul_a_in = mul_a_ff; mul_b_in = mul_b_ff;
      lr_in    = csr_write_en ? csr_write_data : lr_ff;

      w_raddr = '0;  f_raddr = '0;  a_raddr = '0;  h_raddr = '0;  rom_addr = '0;
      w_we = 1'b0;   w_waddr = '0;  w_wdata = '0;
      f_we = 1'b0;   f_waddr = '0;  f_wdata = '0;
      a_we = 1'b0;   a_waddr = '0;  a_wdata = '0;
      h_we = 1'b0;   h_waddr = '0;  h_wdata = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = req_index;
               tgt_in = req_value;
               hit_in = (32'(req_index) < 32'(NW));
               case (req_opcode)
                  OP_WRITE: begin
                     w_we    = (32'(req_index) < 32'(NW));
                     w_waddr = WAW'(req_index);
                     w_wdata = req_value;
                  end
                  OP_LOAD: begin
                     f_we    = (32'(req_index) < 32'(N_INPUTS));
                     f_waddr = IW'(req_index);
                     f_wdata = req_value;
                  end
                  OP_TRAIN: begin
                     i_in = '0;  j_in = '0;  k_in = '0;  acc_in = '0;
                     state_in = ST_F1_RD;
                  end
                  OP_READ: state_in = ST_RD_ISS;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_ISS: begin
            w_raddr  = WAW'(idx_ff);
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: state_in = ST_IDLE;
         ST_MUL:    state_in = ret_ff;     // product lands in prod_ff
         // forward pass, hidden layer
         ST_F1_RD: begin
            w_raddr  = k_ff;
            f_raddr  = i_ff;
            state_in = ST_F1_OP;
         end
         ST_F1_OP: begin
            mul_a_in = 33'(f_q_ff);
            mul_b_in = 33'(w_q_ff);
            ret_in   = ST_F1_ACC;
            state_in = ST_MUL;
         end
         ST_F1_ACC: begin
            acc_in = acc_ff + 56'(raw);
            if (i_last) begin
               state_in = ST_F1_SIG;
            end else begin
               i_in     = i_ff + IW'(1);
               k_in     = k_ff + WAW'(N_HIDDEN);
               state_in = ST_F1_RD;
            end
         end
         ST_F1_SIG: begin
            rom_addr = sig_index(acc_sat);
            state_in = ST_F1_WR;
         end
         ST_F1_WR: begin
            a_we    = 1'b1;
            a_waddr = j_ff;
            a_wdata = rom_q_ff;
            acc_in  = '0;
            i_in    = '0;
            if (j_last) begin
               j_in     = '0;
               state_in = ST_F2_RD;
            end else begin
               j_in     = j_ff + HW'(1);
               k_in     = WAW'(j_ff) + WAW'(1);
               state_in = ST_F1_RD;
            end
         end
         // forward pass, output unit
         ST_F2_RD: begin
            a_raddr  = j_ff;
            w_raddr  = WAW'(NIH) + WAW'(j_ff);
            state_in = ST_F2_OP;
         end
         ST_F2_OP: begin
            mul_a_in = 33'({1'b0, a_q_ff});
            mul_b_in = 33'(w_q_ff);
            ret_in   = ST_F2_ACC;
            state_in = ST_MUL;
         end
         ST_F2_ACC: begin
            acc_in = acc_ff + 56'(raw);
            if (j_last) begin
               state_in = ST_F2_SIG;
            end else begin
               j_in     = j_ff + HW'(1);
               state_in = ST_F2_RD;
            end
         end
         ST_F2_SIG: begin
            rom_addr = sig_index(acc_sat);
            state_in = ST_F2_OUT;
         end
         ST_F2_OUT: begin
            err_in   = sat32(64'(tgt_ff) - 64'($signed({1'b0, rom_q_ff})));
            mul_a_in = 33'({1'b0, rom_q_ff});
            mul_b_in = 33'(Q_ONE) - 33'({1'b0, rom_q_ff});
            ret_in   = ST_OD_A;
            state_in = ST_MUL;
         end
         // output delta and the scaled step
         ST_OD_A: begin
            mul_a_in = 33'(err_ff);
            mul_b_in = 33'(q);
            ret_in   = ST_OD_B;
            state_in = ST_MUL;
         end
         ST_OD_B: begin
            od_in    = q;
            mul_a_in = 33'({1'b0, lr_ff});
            mul_b_in = 33'(q);
            ret_in   = ST_OD_C;
            state_in = ST_MUL;
         end
         ST_OD_C: begin
            step_in  = q;
            j_in     = '0;
            state_in = ST_H_RD;
         end
         // hidden deltas from old output weights, then output weight update
         ST_H_RD: begin
            w_raddr  = WAW'(NIH) + WAW'(j_ff);
            a_raddr  = j_ff;
            state_in = ST_H_OP;
         end
         ST_H_OP: begin
            wo_in    = w_q_ff;
            act_in   = a_q_ff;
            mul_a_in = 33'(od_ff);
            mul_b_in = 33'(w_q_ff);
            ret_in   = ST_H_T1;
            state_in = ST_MUL;
         end
         ST_H_T1: begin
            t1_in    = q;
            mul_a_in = 33'({1'b0, act_ff});
            mul_b_in = 33'(Q_ONE) - 33'({1'b0, act_ff});
            ret_in   = ST_H_T2;
            state_in = ST_MUL;
         end
         ST_H_T2: begin
            mul_a_in = 33'(t1_ff);
            mul_b_in = 33'(q);
            ret_in   = ST_H_T3;
            state_in = ST_MUL;
         end
         ST_H_T3: begin
            mul_a_in = 33'({1'b0, lr_ff});
            mul_b_in = 33'(q);
            ret_in   = ST_H_T4;
            state_in = ST_MUL;
         end
         ST_H_T4: begin
            h_we     = 1'b1;
            h_waddr  = j_ff;
            h_wdata  = q;
            mul_a_in = 33'(step_ff);
            mul_b_in = 33'({1'b0, act_ff});
            ret_in   = ST_H_WR;
            state_in = ST_MUL;
         end
         ST_H_WR: begin
            w_we    = 1'b1;
            w_waddr = WAW'(NIH) + WAW'(j_ff);
            w_wdata = sat32(64'(wo_ff) + 64'(q));
            if (j_last) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_U_RD;
            end else begin
               j_in     = j_ff + HW'(1);
               state_in = ST_H_RD;
            end
         end
         // input-hidden weight update
         ST_U_RD: begin
            w_raddr  = k_ff;
            f_raddr  = i_ff;
            h_raddr  = j_ff;
            state_in = ST_U_OP;
         end
         ST_U_OP: begin
            wo_in    = w_q_ff;
            mul_a_in = 33'(h_q_ff);
            mul_b_in = 33'(f_q_ff);
            ret_in   = ST_U_WR;
            state_in = ST_MUL;
         end
         ST_U_WR: begin
            w_we    = 1'b1;
            w_waddr = k_ff;
            w_wdata = sat32(64'(wo_ff) + 64'(q));
            state_in = ST_U_RD;
            if (i_last) begin
               i_in = '0;
               if (j_last) begin
                  state_in = ST_E_SET;
               end else begin
                  j_in = j_ff + HW'(1);
                  k_in = WAW'(j_ff) + WAW'(1);
               end
            end else begin
               i_in = i_ff + IW'(1);
               k_in = k_ff + WAW'(N_HIDDEN);
            end
         end
         ST_E_SET: begin
            mul_a_in = 33'(err_ff);
            mul_b_in = 33'(err_ff);
            ret_in   = ST_E_OUT;
            state_in = ST_MUL;
         end
         ST_E_OUT: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         lr_ff    <= LR_RESET;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         lr_ff    <= lr_in;
      end
      i_ff     <= i_in;     j_ff    <= j_in;    k_ff    <= k_in;
      acc_ff   <= acc_in;   idx_ff  <= idx_in;  hit_ff  <= hit_in;
      tgt_ff   <= tgt_in;   err_ff  <= err_in;  od_ff   <= od_in;
      step_ff  <= step_in;  wo_ff   <= wo_in;   t1_ff   <= t1_in;
      act_ff   <= act_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      prod_ff  <= mul_a_ff * mul_b_ff;
   end

   // synchronous stores, read data registered
   always_ff @(posedge clock) begin
      if (w_we) w_mem[w_waddr] <= w_wdata;
      if (f_we) f_mem[f_waddr] <= f_wdata;
      if (a_we) a_mem[a_waddr] <= a_wdata;
      if (h_we) h_mem[h_waddr] <= h_wdata;
      w_q_ff   <= w_mem[w_raddr];
      f_q_ff   <= f_mem[f_raddr];
      a_q_ff   <= a_mem[a_raddr];
      h_q_ff   <= h_mem[h_raddr];
      rom_q_ff <= SigRom[rom_addr];
   end

   a_cmd_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_READ || req_opcode == OP_TRAIN) |=> busy)
      else $error("read or train word did not start a command");

   a_one_cycle_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result not a single cycle ending the command");

   a_no_store_write_busy_idle: assert property (@(posedge clock) disable iff (reset)
      (a_we || h_we) |-> busy)
      else $error("training store written outside a train step");

   a_mul_return: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |=> state_ff == $past(ret_ff))
      else $error("multiplier step lost its return point");

endmodule
